@@ src/qmv_pkg.sv @@
// Package: message codes, reply codes, controller states and shared types.
package qmv_pkg;

  localparam int unsigned SenderW = 8;
  localparam int unsigned StampW  = 31;
  localparam int unsigned CmdW    = 3;
  localparam int unsigned KindW   = 3;
  localparam int unsigned EntryW  = SenderW + StampW;

  typedef enum logic [CmdW-1:0] {
    CMD_REQUEST    = 3'd0,
    CMD_LOCKED     = 3'd1,
    CMD_FAILED     = 3'd2,
    CMD_INQUIRE    = 3'd3,
    CMD_RELINQUISH = 3'd4,
    CMD_RELEASE    = 3'd5,
    CMD_EXIT       = 3'd6,
    CMD_IGNORE     = 3'd7
  } cmd_e;

  typedef enum logic [KindW-1:0] {
    KIND_LOCKED     = 3'd0,
    KIND_FAILED     = 3'd1,
    KIND_INQUIRE    = 3'd2,
    KIND_RELINQUISH = 3'd3,
    KIND_ACCESS     = 3'd4
  } kind_e;

  localparam int unsigned RegNodeId     = 0;
  localparam int unsigned RegQuorumSize = 1;
  localparam int unsigned RegClientId   = 2;
  localparam int unsigned CfgIdxW       = 2;
  localparam int unsigned CfgDataW      = 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_PUSH,
    ST_CLEAR,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [SenderW-1:0] sender;
    logic [StampW-1:0]  stamp;
  } entry_t;

  // (stamp, sender) ordering, a strictly ahead of b
  function automatic logic earlier(entry_t a, entry_t b);
    earlier = (a.stamp < b.stamp) || ((a.stamp == b.stamp) && (a.sender < b.sender));
  endfunction

endpackage

@@ src/qmv_msg_if.sv @@
// Valid/ready channel interfaces for input messages and replies.
interface qmv_msg_if;
  logic                         valid;
  logic                         ready;
  logic [qmv_pkg::CmdW-1:0]     cmd;
  logic [qmv_pkg::SenderW-1:0]  sender_id;
  logic [qmv_pkg::StampW-1:0]   stamp;
  modport source (output valid, cmd, sender_id, stamp, input ready);
  modport sink   (input valid, cmd, sender_id, stamp, output ready);
endinterface

interface qmv_reply_if;
  logic                         valid;
  logic                         ready;
  logic [qmv_pkg::SenderW-1:0]  dest_id;
  logic [qmv_pkg::KindW-1:0]    reply_kind;
  logic [qmv_pkg::StampW-1:0]   reply_stamp;
  modport source (output valid, dest_id, reply_kind, reply_stamp, input ready);
  modport sink   (input valid, dest_id, reply_kind, reply_stamp, output ready);
endinterface

@@ src/qmv_queue_mem.sv @@
// Queue entry store: one write port, one registered read port, valid bits in flops.
module qmv_queue_mem #(
  parameter int unsigned Depth = 10,
  parameter int unsigned IdxW  = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_en_i,
  input  logic [IdxW-1:0]       wr_idx_i,
  input  qmv_pkg::entry_t       wr_data_i,
  input  logic                  clr_en_i,
  input  logic [IdxW-1:0]       clr_idx_i,
  input  logic [IdxW-1:0]       rd_idx_i,
  output qmv_pkg::entry_t       rd_data_o,
  output logic [Depth-1:0]      valid_o
);

  qmv_pkg::entry_t mem_q [Depth];
  logic [Depth-1:0] valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_idx_i] <= wr_data_i;
    end
    rd_data_o <= mem_q[rd_idx_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (clr_en_i) valid_q[clr_idx_i] <= 1'b0;
      if (wr_en_i)  valid_q[wr_idx_i]  <= 1'b1;
    end
  end

  assign valid_o = valid_q;

endmodule

@@ src/quorum_mutex_voter_core.sv @@
// Maekawa quorum voter: one message in, at most one reply out, queues in
// memories with one write port and one registered read port, scanned one
// entry per cycle. A message passes through an accept step, a queue scan
// (one read per cycle plus the read latency) and a decide step; a reply adds
// its output beat. Relinquish, and release with a waiter queued, add a second
// scan to free the chosen slot and an output state. A new message is taken
// only when the controller is idle and the reply register is empty, so a
// stalled reply holds off the input. No clearing pass follows reset. After an
// exit message, later messages are taken and dropped without a scan.
module quorum_mutex_voter_core #(
  parameter int unsigned QueueDepth = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  qmv_msg_if.sink                       msg,
  qmv_reply_if.source                   reply,
  input  logic                          cfg_we_i,
  input  logic [qmv_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [qmv_pkg::CfgDataW-1:0]  cfg_data_i
);

  localparam int unsigned IdxW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  typedef logic [qmv_pkg::SenderW-1:0] snd_t;
  typedef logic [qmv_pkg::StampW-1:0]  stm_t;

  // configuration
  snd_t       node_id_q, client_id_q;
  logic [3:0] quorum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_id_q   <= '0;
      quorum_q    <= 4'd5;
      client_id_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        qmv_pkg::CfgIdxW'(qmv_pkg::RegNodeId):     node_id_q   <= cfg_data_i;
        qmv_pkg::CfgIdxW'(qmv_pkg::RegQuorumSize): quorum_q    <= cfg_data_i[3:0];
        qmv_pkg::CfgIdxW'(qmv_pkg::RegClientId):   client_id_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // scalar state
  qmv_pkg::state_e state_q, state_d;
  logic            locked_q, locked_d, inquiry_out_q, inquiry_out_d;
  logic            failed_q, failed_d, halted_q, halted_d;
  qmv_pkg::entry_t holder_q, holder_d;
  logic [4:0]      grant_q, grant_d;
  logic [CntW-1:0] held_q, held_d;

  // message latch
  qmv_pkg::cmd_e   cmd_q, cmd_d;
  qmv_pkg::entry_t in_q, in_d;

  // scan
  logic [IdxW:0]   cnt_q, cnt_d;     // read issue counter
  logic            rvld_q;           // read data valid for index ridx_q
  logic [IdxW-1:0] ridx_q;
  logic            best_v_q, best_v_d, prec_q, prec_d;
  qmv_pkg::entry_t best_q, best_d;
  logic [IdxW-1:0] bidx_q, bidx_d;   // slot to clear
  logic            fv_q, fv_d;       // free slot found
  logic [IdxW-1:0] free_q, free_d;

  // output register
  logic            ov_q, ov_d;
  snd_t            odst_q, odst_d;
  logic [qmv_pkg::KindW-1:0] okind_q, okind_d;
  stm_t            ostm_q, ostm_d;

  // memories
  logic            w_we, w_clr, i_we, i_clr;
  logic [IdxW-1:0] w_widx, w_cidx, i_cidx, rd_idx;
  qmv_pkg::entry_t w_wd, w_rd, i_rd;
  logic [QueueDepth-1:0] w_vld, i_vld;

  qmv_queue_mem #(.Depth(QueueDepth), .IdxW(IdxW)) u_wait (
    .clk_i, .rst_ni, .wr_en_i(w_we), .wr_idx_i(w_widx), .wr_data_i(w_wd),
    .clr_en_i(w_clr), .clr_idx_i(w_cidx), .rd_idx_i(rd_idx),
    .rd_data_o(w_rd), .valid_o(w_vld)
  );

  qmv_queue_mem #(.Depth(QueueDepth), .IdxW(IdxW)) u_inq (
    .clk_i, .rst_ni, .wr_en_i(i_we), .wr_idx_i(free_q), .wr_data_i(in_q),
    .clr_en_i(i_clr), .clr_idx_i(i_cidx), .rd_idx_i(rd_idx),
    .rd_data_o(i_rd), .valid_o(i_vld)
  );

  assign rd_idx     = cnt_q[IdxW-1:0];
  assign msg.ready  = (state_q == qmv_pkg::ST_IDLE) && !ov_q;
  assign reply.valid       = ov_q;
  assign reply.dest_id     = odst_q;
  assign reply.reply_kind  = okind_q;
  assign reply.reply_stamp = ostm_q;

  logic scan_done;
  logic cur_v, w_cur_v;
  assign scan_done = (cnt_q == (IdxW+1)'(QueueDepth)) && !rvld_q;
  assign w_cur_v   = w_vld[ridx_q];
  // failed and inquire work on the inquire queue
  assign cur_v     = ((cmd_q == qmv_pkg::CMD_FAILED) || (cmd_q == qmv_pkg::CMD_INQUIRE)) ?
                     i_vld[ridx_q] : w_cur_v;

  always_comb begin
    state_d = state_q; locked_d = locked_q; inquiry_out_d = inquiry_out_q;
    failed_d = failed_q; halted_d = halted_q; holder_d = holder_q;
    grant_d = grant_q; held_d = held_q; cmd_d = cmd_q; in_d = in_q;
    cnt_d = cnt_q; best_v_d = best_v_q; best_d = best_q; bidx_d = bidx_q;
    prec_d = prec_q; fv_d = fv_q; free_d = free_q;
    ov_d = ov_q; odst_d = odst_q; okind_d = okind_q; ostm_d = ostm_q;
    w_we = 1'b0; w_clr = 1'b0; i_we = 1'b0; i_clr = 1'b0;
    w_widx = free_q; w_wd = in_q; w_cidx = bidx_q; i_cidx = bidx_q;

    if (ov_q && reply.ready) ov_d = 1'b0;

    unique case (state_q)
      qmv_pkg::ST_IDLE: begin
        if (msg.valid && msg.ready) begin
          cmd_d = qmv_pkg::cmd_e'(msg.cmd);
          in_d  = '{sender: msg.sender_id, stamp: msg.stamp};
          cnt_d = '0; best_v_d = 1'b0; prec_d = 1'b0; fv_d = 1'b0;
          if (!halted_q) state_d = qmv_pkg::ST_SCAN;
        end
      end
      qmv_pkg::ST_SCAN: begin
        // one read per cycle; evaluate the entry read last cycle
        if (cnt_q != (IdxW+1)'(QueueDepth)) cnt_d = cnt_q + 1'b1;
        if (rvld_q) begin
          if (!cur_v && !fv_d) begin
            fv_d = 1'b1; free_d = ridx_q;
          end
          if (cmd_q == qmv_pkg::CMD_FAILED) begin
            if (cur_v && !best_v_d) begin
              best_v_d = 1'b1; best_d = i_rd; bidx_d = ridx_q;
            end
          end else if (w_cur_v) begin
            if (qmv_pkg::earlier(w_rd, in_q)) prec_d = 1'b1;
            if (!best_v_d || qmv_pkg::earlier(w_rd, best_d)) begin
              best_v_d = 1'b1; best_d = w_rd;
            end
          end
        end
        if (scan_done) state_d = qmv_pkg::ST_DECIDE;
      end
      qmv_pkg::ST_DECIDE: begin
        state_d = qmv_pkg::ST_IDLE;
        unique case (cmd_q)
          qmv_pkg::CMD_REQUEST: begin
            if (!locked_q) begin
              locked_d = 1'b1; holder_d = in_q;
              ov_d = 1'b1; odst_d = in_q.sender;
              okind_d = qmv_pkg::KIND_LOCKED; ostm_d = in_q.stamp;
            end else begin
              w_we = fv_q;
              if (qmv_pkg::earlier(holder_q, in_q) || prec_q) begin
                ov_d = 1'b1; odst_d = in_q.sender;
                okind_d = qmv_pkg::KIND_FAILED; ostm_d = in_q.stamp;
              end else if (!inquiry_out_q) begin
                inquiry_out_d = 1'b1;
                ov_d = 1'b1; odst_d = holder_q.sender;
                okind_d = qmv_pkg::KIND_INQUIRE; ostm_d = holder_q.stamp;
              end
            end
          end
          qmv_pkg::CMD_LOCKED: begin
            grant_d = grant_q + 5'd1;
            if ($signed(grant_d) >= $signed({2'b00, quorum_q})) begin
              grant_d = '0;
              ov_d = 1'b1; odst_d = client_id_q;
              okind_d = qmv_pkg::KIND_ACCESS; ostm_d = holder_q.stamp;
            end
          end
          qmv_pkg::CMD_FAILED: begin
            failed_d = 1'b1;
            if (held_q != '0 && best_v_q) begin
              held_d = held_q - 1'b1; i_clr = 1'b1;
              ov_d = 1'b1; odst_d = best_q.sender;
              okind_d = qmv_pkg::KIND_RELINQUISH; ostm_d = best_q.stamp;
            end
          end
          qmv_pkg::CMD_INQUIRE: begin
            if (failed_q) begin
              grant_d = grant_q - 5'd1;
              ov_d = 1'b1; odst_d = in_q.sender;
              okind_d = qmv_pkg::KIND_RELINQUISH; ostm_d = in_q.stamp;
            end else begin
              if (held_q != CntW'(QueueDepth)) held_d = held_q + 1'b1;
              i_we = fv_q;
            end
          end
          qmv_pkg::CMD_RELINQUISH: begin
            // holder joins the queue if a slot is free, then the minimum over both is granted
            if (!best_v_q || qmv_pkg::earlier(holder_q, best_q)) begin
              best_d = holder_q;
            end
            if (!fv_q) begin
              // holder dropped; grant the queued minimum
              best_d = best_q;
            end
            best_v_d = best_v_q || fv_q;
            if (fv_q) begin
              w_we = 1'b1; w_wd = holder_q;
            end
            if (best_v_d) begin
              cnt_d = '0; state_d = qmv_pkg::ST_CLEAR;
            end
          end
          qmv_pkg::CMD_RELEASE: begin
            inquiry_out_d = 1'b0;
            if (in_q.sender == node_id_q) held_d = '0;
            if (best_v_q) begin
              cnt_d = '0; state_d = qmv_pkg::ST_CLEAR;
            end else begin
              locked_d = 1'b0;
            end
          end
          qmv_pkg::CMD_EXIT:   halted_d = 1'b1;
          qmv_pkg::CMD_IGNORE: ;
          default: ;
        endcase
      end
      qmv_pkg::ST_CLEAR: begin
        // find first valid slot whose sender matches the chosen minimum
        if (cnt_q != (IdxW+1)'(QueueDepth)) cnt_d = cnt_q + 1'b1;
        if (rvld_q && w_cur_v && (w_rd.sender == best_q.sender) && !prec_q) begin
          prec_d = 1'b1; w_clr = 1'b1; w_cidx = ridx_q;
        end
        if (scan_done) begin
          holder_d = best_q;
          state_d  = qmv_pkg::ST_OUT;
        end
      end
      qmv_pkg::ST_OUT: begin
        ov_d = 1'b1; odst_d = best_q.sender;
        okind_d = qmv_pkg::KIND_LOCKED; ostm_d = best_q.stamp;
        state_d = qmv_pkg::ST_IDLE;
      end
      default: state_d = qmv_pkg::ST_IDLE;
    endcase
    if (state_q == qmv_pkg::ST_DECIDE && state_d == qmv_pkg::ST_CLEAR) prec_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= qmv_pkg::ST_IDLE;
      locked_q <= 1'b0; inquiry_out_q <= 1'b0; failed_q <= 1'b0; halted_q <= 1'b0;
      holder_q <= '0; grant_q <= '0; held_q <= '0;
      cnt_q <= '0; rvld_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      locked_q <= locked_d; inquiry_out_q <= inquiry_out_d;
      failed_q <= failed_d; halted_q <= halted_d;
      holder_q <= holder_d; grant_q <= grant_d; held_q <= held_d;
      cnt_q <= cnt_d; ov_q <= ov_d;
      rvld_q <= ((state_q == qmv_pkg::ST_SCAN) || (state_q == qmv_pkg::ST_CLEAR))
                && (cnt_q != (IdxW+1)'(QueueDepth));
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; in_q <= in_d; ridx_q <= rd_idx;
    best_v_q <= best_v_d; best_q <= best_d; bidx_q <= bidx_d; prec_q <= prec_d;
    fv_q <= fv_d; free_q <= free_d;
    odst_q <= odst_d; okind_q <= okind_d; ostm_q <= ostm_d;
  end

`ifndef SYNTH
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != qmv_pkg::ST_IDLE) |-> !msg.ready)
    else $error("message taken while busy");
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q)
    else $error("halt flag cleared");
  a_failed_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    failed_q |=> failed_q)
    else $error("failed flag cleared");
  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= CntW'(QueueDepth))
    else $error("inquiry count out of range");
`endif

endmodule
